### rtl/etm_pkg.sv
// Shared constants, tables and types of the exponential tone map.
`default_nettype none

package etm_pkg;

	// Fixed field widths
	localparam int PIX_W     = 24;
	localparam int SCALE_W   = 16;
	localparam int PROD_W    = PIX_W + SCALE_W;
	localparam int FRAC_W    = 16;
	localparam int OUT_W     = 16;

	// Exponential datapath: Q0.32 values with one guard bit for 1.0
	localparam int Q_W       = 33;
	localparam int SUM_W     = 35;
	localparam int TERMS     = 16;
	localparam int INT_LIMIT = 32;
	localparam int N_W       = 5;
	localparam int RECIP_W   = 34;

	localparam int IN_FRAC_BITS_DEF = 12;
	localparam int OUT_BITS_DEF     = 16;

	localparam logic [SCALE_W-1:0] SCALE_RST = 16'd3277;
	localparam logic [Q_W-1:0]     Q32_ONE   = 33'h1_0000_0000;

	// exp(-1) in Q0.32, from the same truncated series at f = 1.0
	localparam logic [31:0] EXP_M1 = 32'd1580030169;

	// Reciprocals ceil(2^s / k) that give an exact floor(x / k) for 33-bit x
	localparam logic [RECIP_W-1:0] RECIP_TAB [1:TERMS] = '{
		34'd8589934592,  34'd8589934592,  34'd11453246123, 34'd8589934592,
		34'd13743895348, 34'd11453246123, 34'd9817068106,  34'd8589934592,
		34'd15270994831, 34'd13743895348, 34'd12494450316, 34'd11453246123,
		34'd10572227191, 34'd9817068106,  34'd9162596899,  34'd8589934592
	};
	localparam int RECIP_SH [1:TERMS] = '{
		33, 34, 35, 35, 36, 36, 36, 36, 37, 37, 37, 37, 37, 37, 37, 37
	};

	// Number of root bits for a given input fraction width
	function automatic int root_width(input int in_frac_bits);
		return (PROD_W + FRAC_W - in_frac_bits + 1) >> 1;
	endfunction

	typedef struct packed {
		logic [OUT_W-1:0] blue;
		logic [OUT_W-1:0] green;
		logic [OUT_W-1:0] red;
		logic             last;
	} pix_t;

endpackage

`default_nettype wire

### rtl/etm_root.sv
// Exposure multiply and pipelined integer square root, one root bit per stage.
`default_nettype none

module etm_root #(
	parameter int IN_FRAC_BITS = etm_pkg::IN_FRAC_BITS_DEF,
	parameter int ROOT_W       = etm_pkg::root_width(etm_pkg::IN_FRAC_BITS_DEF)
) (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [etm_pkg::PIX_W-1:0]   pix,
	input  wire logic [etm_pkg::SCALE_W-1:0] scale,
	output logic      [ROOT_W-1:0]           root
);
	import etm_pkg::*;

	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 3;
	localparam int SH    = FRAC_W - IN_FRAC_BITS;

	logic [RAD_W-1:0]  rad_s  [ROOT_W+1];
	logic [REM_W-1:0]  rem_s  [ROOT_W+1];
	logic [ROOT_W-1:0] root_s [ROOT_W+1];

	logic [RAD_W-1:0]  rad_nxt  [ROOT_W];
	logic [REM_W-1:0]  rem_nxt  [ROOT_W];
	logic [ROOT_W-1:0] root_nxt [ROOT_W];
	logic [REM_W-1:0]  rem_try  [ROOT_W];
	logic [REM_W-1:0]  trial    [ROOT_W];
	logic [PROD_W-1:0] prod;

	assign prod = PROD_W'(pix) * PROD_W'(scale);

	always_comb begin
		for (int j = 0; j < ROOT_W; j++) begin
			rem_try[j] = {rem_s[j][REM_W-3:0], rad_s[j][RAD_W-1 -: 2]};
			trial[j]   = REM_W'({root_s[j], 2'b01});
			rad_nxt[j] = rad_s[j] << 2;
			if (rem_try[j] >= trial[j]) begin
				rem_nxt[j]  = rem_try[j] - trial[j];
				root_nxt[j] = {root_s[j][ROOT_W-2:0], 1'b1};
			end else begin
				rem_nxt[j]  = rem_try[j];
				root_nxt[j] = {root_s[j][ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s[0]  <= RAD_W'(prod) << SH;
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			for (int j = 0; j < ROOT_W; j++) begin
				rad_s[j+1]  <= rad_nxt[j];
				rem_s[j+1]  <= rem_nxt[j];
				root_s[j+1] <= root_nxt[j];
			end
		end
	end

	assign root = root_s[ROOT_W];

endmodule

`default_nettype wire

### rtl/etm_exp.sv
// Pipelined 1 - exp(-v): series for the fraction, repeated exp(-1) for the integer part.
`default_nettype none

module etm_exp #(
	parameter int OUT_BITS = etm_pkg::OUT_BITS_DEF,
	parameter int ROOT_W   = etm_pkg::root_width(etm_pkg::IN_FRAC_BITS_DEF)
) (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [ROOT_W-1:0]         root,
	output logic      [etm_pkg::OUT_W-1:0] tone
);
	import etm_pkg::*;

	localparam int NS    = 2 * TERMS + 1;
	localparam int NP    = INT_LIMIT;
	localparam int MA_W  = Q_W + FRAC_W;
	localparam int MB_W  = Q_W + RECIP_W;
	localparam int MP_W  = Q_W + 32;
	localparam int RND_W = Q_W + OUT_BITS + 1;
	localparam int R_W   = RND_W - 32;
	localparam logic [R_W-1:0] MAXV = R_W'((64'd1 << OUT_BITS) - 64'd1);

	// series stages: odd stages hold term * f / 2^16, even stages hold the new term
	logic [Q_W-1:0]    acc_s [NS];
	logic [SUM_W-1:0]  pos_s [NS];
	logic [SUM_W-1:0]  neg_s [NS];
	logic [FRAC_W-1:0] f_s   [NS];
	logic [N_W-1:0]    n_s   [NS];
	logic              big_s [NS];

	logic [MA_W-1:0] mul_a [1:TERMS];
	logic [MB_W-1:0] mul_b [1:TERMS];
	logic [Q_W-1:0]  term  [1:TERMS];

	// integer-part stages
	logic [Q_W-1:0] pe_s   [NP];
	logic [N_W-1:0] pn_s   [NP];
	logic           pbig_s [NP];
	logic [MP_W-1:0] mul_p [NP-1];
	logic [Q_W-1:0]  pe_nxt [NP-1];

	logic [SUM_W-1:0] diff;
	logic [Q_W-1:0]   e_fin;
	logic [Q_W-1:0]   e_use;
	logic [RND_W-1:0] rnd;
	logic [R_W-1:0]   r;
	logic [R_W-1:0]   r_sat;
	logic             big_in;

	assign big_in = 32'(root >> FRAC_W) >= 32'(INT_LIMIT);

	always_comb begin
		for (int k = 1; k <= TERMS; k++) begin
			mul_a[k] = MA_W'(acc_s[2*k-2]) * MA_W'(f_s[2*k-2]);
			mul_b[k] = MB_W'(acc_s[2*k-1]) * MB_W'(RECIP_TAB[k]);
			term[k]  = Q_W'(mul_b[k] >> RECIP_SH[k]);
		end
	end

	always_comb begin
		diff = pos_s[NS-1] - neg_s[NS-1];
		if (neg_s[NS-1] >= pos_s[NS-1]) begin
			e_fin = '0;
		end else if (diff > SUM_W'(Q32_ONE)) begin
			e_fin = Q32_ONE;
		end else begin
			e_fin = Q_W'(diff);
		end
	end

	always_comb begin
		for (int i = 0; i < NP - 1; i++) begin
			mul_p[i]  = MP_W'(pe_s[i]) * MP_W'(EXP_M1);
			pe_nxt[i] = (pn_s[i] > N_W'(i)) ? Q_W'(mul_p[i] >> 32) : pe_s[i];
		end
	end

	always_comb begin
		e_use = pbig_s[NP-1] ? '0 : pe_s[NP-1];
		rnd   = (RND_W'(Q32_ONE - e_use) << OUT_BITS) + (RND_W'(1) << 31);
		r     = rnd[RND_W-1:32];
		r_sat = (r > MAXV) ? MAXV : r;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s[0] <= Q32_ONE;
			pos_s[0] <= SUM_W'(Q32_ONE);
			neg_s[0] <= '0;
			f_s[0]   <= root[FRAC_W-1:0];
			n_s[0]   <= N_W'(32'(root >> FRAC_W));
			big_s[0] <= big_in;
			for (int k = 1; k <= TERMS; k++) begin
				acc_s[2*k-1] <= mul_a[k][MA_W-1:FRAC_W];
				pos_s[2*k-1] <= pos_s[2*k-2];
				neg_s[2*k-1] <= neg_s[2*k-2];
				f_s[2*k-1]   <= f_s[2*k-2];
				n_s[2*k-1]   <= n_s[2*k-2];
				big_s[2*k-1] <= big_s[2*k-2];

				acc_s[2*k] <= term[k];
				if (k % 2 == 1) begin
					pos_s[2*k] <= pos_s[2*k-1];
					neg_s[2*k] <= neg_s[2*k-1] + SUM_W'(term[k]);
				end else begin
					pos_s[2*k] <= pos_s[2*k-1] + SUM_W'(term[k]);
					neg_s[2*k] <= neg_s[2*k-1];
				end
				f_s[2*k]   <= f_s[2*k-1];
				n_s[2*k]   <= n_s[2*k-1];
				big_s[2*k] <= big_s[2*k-1];
			end

			pe_s[0]   <= e_fin;
			pn_s[0]   <= n_s[NS-1];
			pbig_s[0] <= big_s[NS-1];
			for (int i = 0; i < NP - 1; i++) begin
				pe_s[i+1]   <= pe_nxt[i];
				pn_s[i+1]   <= pn_s[i];
				pbig_s[i+1] <= pbig_s[i];
			end

			tone <= OUT_W'(r_sat);
		end
	end

endmodule

`default_nettype wire

### rtl/etm_out.sv
// Output register with one skid entry; freezes the pipeline only while the skid is full.
`default_nettype none

module etm_out (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire etm_pkg::pix_t in_beat,
	output logic               advance,
	input  wire logic          m_tready,
	output logic               m_tvalid,
	output etm_pkg::pix_t      out_beat
);
	import etm_pkg::*;

	logic skid_v_q;
	pix_t skid_q;
	logic fire;

	assign advance = !skid_v_q;
	assign fire    = in_valid && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!m_tvalid || m_tready) begin
			if (skid_v_q) begin
				m_tvalid <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				m_tvalid <= fire;
			end
		end else if (fire) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!m_tvalid || m_tready) begin
			out_beat <= skid_v_q ? skid_q : in_beat;
		end else if (fire) begin
			skid_q <= in_beat;
		end
	end

endmodule

`default_nettype wire

### rtl/exponential_tone_map.sv
// Top level of the exponential tone map: per-pixel 1 - exp(-sqrt(intensity * exposure)).
//
// Channel   Direction  Handshake              Payload
// s_*       in         s_tvalid / s_tready    s_tdata = red, green, blue (24 b each), s_tlast
// m_*       out        m_tvalid / m_tready    m_tdata = red, green, blue (16 b each), m_tlast
// cfg_*     in         cfg_valid / cfg_ready  cfg_data = exposure scale, Q0.16
//
// One pixel a cycle, sustained while the skid entry is free. The output beat passes through
// these registers in order: multiply, one stage
// per root bit, root capture, 32 series stages, clamp, 31 exp(-1) stages, rounding, output.
// Reset clears the valid line and the output handshake, holds s_tready and cfg_ready low
// until the first edge after reset and loads the exposure scale with about 0.05.
// A stalled output beat is held and the next finished pixel parks in a skid entry; the whole
// pipeline freezes only while that entry is full, so no beat is dropped or repeated.
`default_nettype none

module exponential_tone_map #(
	parameter int IN_FRAC_BITS = etm_pkg::IN_FRAC_BITS_DEF,
	parameter int OUT_BITS     = etm_pkg::OUT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [3*etm_pkg::PIX_W-1:0]   s_tdata,  // red_in, green_in, blue_in
	input  wire logic                          s_tlast,  // frame_end_in

	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [3*etm_pkg::OUT_W-1:0]   m_tdata,  // red_out, green_out, blue_out
	output logic                               m_tlast,  // frame_end_out

	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [etm_pkg::SCALE_W-1:0]   cfg_data  // exposure_scale
);
	import etm_pkg::*;

	localparam int ROOT_W  = root_width(IN_FRAC_BITS);
	localparam int ROOT_LAT = ROOT_W + 1;
	localparam int EXP_LAT  = 2 * TERMS + INT_LIMIT + 2;
	localparam int LAT      = ROOT_LAT + EXP_LAT;

	logic                 en;
	logic                 run_q;
	logic [SCALE_W-1:0]   scale_q;
	logic                 v_s    [LAT];
	logic                 last_s [LAT];
	logic [ROOT_W-1:0]    root   [3];
	logic [OUT_W-1:0]     tone   [3];
	pix_t                 end_beat;
	pix_t                 out_beat;

	// Hold both input channels off until the first edge after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else begin
			run_q <= 1'b1;
		end
	end

	// Scale: ready out of reset; user writes only while pipeline is empty; not enforced.
	assign cfg_ready = run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			scale_q <= cfg_data;
		end
	end

	// Take a new beat whenever the pipeline advances, once out of reset.
	assign s_tready = en && run_q;

	// Valid line: advance with the data registers, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) begin
				v_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s[0] <= s_tvalid && s_tready;
			for (int i = 1; i < LAT; i++) begin
				v_s[i] <= v_s[i-1];
			end
		end
	end

	// Frame-end flag rides along with its pixel.
	always_ff @(posedge clk) begin
		if (en) begin
			last_s[0] <= s_tlast;
			for (int i = 1; i < LAT; i++) begin
				last_s[i] <= last_s[i-1];
			end
		end
	end

	// One root and one exponential pipeline per color channel.
	for (genvar c = 0; c < 3; c++) begin : g_chan
		etm_root #(
			.IN_FRAC_BITS (IN_FRAC_BITS),
			.ROOT_W       (ROOT_W)
		) u_root (
			.clk   (clk),
			.en    (en),
			.pix   (s_tdata[c*PIX_W +: PIX_W]),
			.scale (scale_q),
			.root  (root[c])
		);

		etm_exp #(
			.OUT_BITS (OUT_BITS),
			.ROOT_W   (ROOT_W)
		) u_exp (
			.clk  (clk),
			.en   (en),
			.root (root[c]),
			.tone (tone[c])
		);
	end

	assign end_beat.red   = tone[0];
	assign end_beat.green = tone[1];
	assign end_beat.blue  = tone[2];
	assign end_beat.last  = last_s[LAT-1];

	// Output register plus skid entry; its free flag drives the pipeline enable.
	etm_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s[LAT-1]),
		.in_beat  (end_beat),
		.advance  (en),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.out_beat (out_beat)
	);

	assign m_tdata = {out_beat.blue, out_beat.green, out_beat.red};
	assign m_tlast = out_beat.last;

endmodule

`default_nettype wire

### tb/sv/exponential_tone_map_tb.sv
// Self-checking testbench for the exponential tone map: a directed table and random pixels.
`default_nettype none

module exponential_tone_map_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import etm_pkg::*;

	// Drain wait: the latency of the default build, with some margin on top.
	localparam int DRAIN_CYCLES = 120;
	localparam int HOLD_LEN     = 400;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [3*PIX_W-1:0] s_tdata;   // red_in, green_in, blue_in
	logic s_tlast;                 // frame_end_in
	logic m_tvalid;
	logic m_tready;
	logic [3*OUT_W-1:0] m_tdata;   // red_out, green_out, blue_out
	logic m_tlast;                 // frame_end_out
	logic cfg_valid;
	logic cfg_ready;
	logic [SCALE_W-1:0] cfg_data;

	typedef struct {
		logic [OUT_W-1:0] red;
		logic [OUT_W-1:0] green;
		logic [OUT_W-1:0] blue;
		logic             last;
	} tone_px_t;

	// One directed row: input pixel, and a typed-in result where it is obvious.
	typedef struct {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             last;
		bit               typed;
		logic [OUT_W-1:0] out_val;
	} dir_row_t;

	tone_px_t         tone_q[$];
	logic [SCALE_W-1:0] exposure;
	int               err_cnt;
	bit               quiet;
	bit               hold_go;

	exponential_tone_map dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the handshake hangs.
	initial begin
		#3ms;
		$display("exponential_tone_map_tb: FAIL");
		$finish;
	end

	// Integer square root, bit by bit.
	function automatic longint unsigned int_sqrt(input longint unsigned a);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > a) b >>= 2;
		while (b != 0) begin
			if (a >= r + b) begin
				a -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// exp(-f) for f in Q.16, truncated Taylor series, result Q0.32.
	function automatic longint unsigned exp_frac_q32(input longint unsigned f);
		longint unsigned pos, neg, term;
		pos = 64'd1 << 32;
		neg = 0;
		term = 64'd1 << 32;
		for (int k = 1; k <= TERMS; k++) begin
			term = (term * f) / (longint'(k) << 16);
			if (k & 1) neg += term;
			else pos += term;
		end
		if (neg >= pos) return 0;
		pos -= neg;
		return (pos > (64'd1 << 32)) ? (64'd1 << 32) : pos;
	endfunction

	// 1 - exp(-sqrt(intensity * exposure)) for one channel.
	function automatic logic [OUT_W-1:0] tone_chan(input logic [PIX_W-1:0] pix,
			input logic [SCALE_W-1:0] gain);
		longint unsigned prod, root, n, e, e1, r;
		prod = longint'(pix) * longint'(gain);
		root = int_sqrt(prod << (16 - IN_FRAC_BITS_DEF));
		n = root >> 16;
		if (n >= INT_LIMIT) begin
			e = 0;
		end else begin
			e = exp_frac_q32(root & 64'hFFFF);
			e1 = exp_frac_q32(64'd1 << 16);
			for (longint unsigned i = 0; i < n; i++) e = (e * e1) >> 32;
		end
		r = ((((64'd1 << 32) - e) << OUT_BITS_DEF) + (64'd1 << 31)) >> 32;
		if (r > 64'hFFFF) r = 64'hFFFF;
		return r[OUT_W-1:0];
	endfunction

	task automatic report_mismatch(input string field, input logic [OUT_W-1:0] got,
			input logic [OUT_W-1:0] want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
		err_cnt++;
	endtask

	// Compare every output beat with the oldest expected pixel.
	always @(posedge clk) begin
		tone_px_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (tone_q.size() == 0) begin
				$display("[%0t] output beat with no pixel pending", $realtime);
				err_cnt++;
			end else begin
				want = tone_q.pop_front();
				if (m_tdata[OUT_W-1:0] !== want.red)
					report_mismatch("red", m_tdata[OUT_W-1:0], want.red);
				if (m_tdata[2*OUT_W-1:OUT_W] !== want.green)
					report_mismatch("green", m_tdata[2*OUT_W-1:OUT_W], want.green);
				if (m_tdata[3*OUT_W-1:2*OUT_W] !== want.blue)
					report_mismatch("blue", m_tdata[3*OUT_W-1:2*OUT_W], want.blue);
				if (m_tlast !== want.last)
					report_mismatch("frame end", OUT_W'(m_tlast), OUT_W'(want.last));
			end
		end
	end

	// Output side: random back-pressure, a quiet window, and one long hold-off,
	// counted here, that lets the pipeline fill up and stall the input.
	initial begin
		int hold_left;
		bit hold_seen;
		hold_left = 0;
		hold_seen = 1'b0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_seen) begin
				hold_seen = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				m_tready = 1'b0;
				hold_left--;
			end else if (quiet) begin
				m_tready = 1'b1;
			end else begin
				m_tready = ($urandom_range(99) >= 31);
			end
		end
	end

	// Offer one pixel, hold it until accepted, and queue its expected result.
	task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
			input logic [PIX_W-1:0] b, input logic last, input bit typed,
			input logic [OUT_W-1:0] out_val);
		tone_px_t want;
		while (!quiet && $urandom_range(99) < 31) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {b, g, r};
		s_tlast  = last;
		do @(posedge clk); while (!s_tready);
		if (typed) begin
			want.red = out_val; want.green = out_val; want.blue = out_val;
		end else begin
			want.red   = tone_chan(r, exposure);
			want.green = tone_chan(g, exposure);
			want.blue  = tone_chan(b, exposure);
		end
		want.last = last;
		tone_q = {tone_q, want};
		@(negedge clk);
	endtask

	// Let the pipeline drain, then load a new exposure scale.
	task automatic set_exposure(input logic [SCALE_W-1:0] v);
		s_tvalid = 1'b0;
		wait (tone_q.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		exposure = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [PIX_W-1:0] rand_pix();
		case ($urandom_range(3))
			0: return PIX_W'($urandom_range(0, 255));
			1: return PIX_W'($urandom_range(0, 16'hFFFF));
			2: return PIX_W'(24'hFFFFFF - $urandom_range(0, 4095));
			default: return PIX_W'($urandom());
		endcase
	endfunction

	dir_row_t dir_tab[$];
	logic [SCALE_W-1:0] scale_plan[5];

	initial begin
		err_cnt   = 0;
		quiet     = 1'b0;
		hold_go   = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		exposure  = SCALE_RST;

		// Directed rows: zero gives zero, full-scale intensity saturates.
		dir_tab = '{
			'{24'd0,       24'd0,       24'd0,       1'b0, 1'b1, 16'd0},
			'{24'hFFFFFF,  24'hFFFFFF,  24'hFFFFFF,  1'b1, 1'b1, 16'hFFFF},
			'{24'd1,       24'd2,       24'd3,       1'b0, 1'b0, 16'd0},
			'{24'h001000,  24'h000800,  24'h002000,  1'b0, 1'b0, 16'd0},
			'{24'h010000,  24'h100000,  24'h800000,  1'b1, 1'b0, 16'd0},
			'{24'hAAAAAA,  24'h555555,  24'h0F0F0F,  1'b0, 1'b0, 16'd0},
			'{24'h7FFFFF,  24'h800000,  24'h000001,  1'b1, 1'b0, 16'd0},
			'{24'd0,       24'hFFFFFF,  24'd4096,    1'b0, 1'b0, 16'd0}
		};

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset scale first, then the extremes of the register.
		foreach (dir_tab[i])
			send_pixel(dir_tab[i].red, dir_tab[i].green, dir_tab[i].blue,
				dir_tab[i].last, dir_tab[i].typed, dir_tab[i].out_val);
		set_exposure(16'hFFFF);
		foreach (dir_tab[i])
			send_pixel(dir_tab[i].red, dir_tab[i].green, dir_tab[i].blue,
				dir_tab[i].last, dir_tab[i].typed, dir_tab[i].out_val);
		set_exposure(16'd0);
		send_pixel(24'hFFFFFF, 24'h123456, 24'd1, 1'b1, 1'b1, 16'd0);

		// Random phases across several settings of the exposure scale.
		scale_plan = '{SCALE_RST, 16'hFFFF, 16'd1, 16'd0, 16'($urandom())};
		foreach (scale_plan[p]) begin
			set_exposure(scale_plan[p]);
			for (int i = 0; i < 205; i++) begin
				quiet = (p == 1 && i >= 40 && i < 140);
				if (p == 2 && i == 20)
					hold_go = 1'b1;
				send_pixel(rand_pix(), rand_pix(), rand_pix(), 1'($urandom()), 1'b0, 16'd0);
			end
			quiet = 1'b0;
		end
		s_tvalid = 1'b0;

		wait (tone_q.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (err_cnt == 0)
			$display("exponential_tone_map_tb: PASS");
		else
			$display("exponential_tone_map_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
rtl/etm_pkg.sv
rtl/etm_root.sv
rtl/etm_exp.sv
rtl/etm_out.sv
rtl/exponential_tone_map.sv
tb/sv/exponential_tone_map_tb.sv
